>>> src/xxh64_pkg.sv
// ----------------------------------------------------------------------------
// xxh64_pkg: shared types and constants for the xxHash64 stream hasher
// Primes, field widths and the queue item format.
// ----------------------------------------------------------------------------
package xxh64_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;
  localparam logic [63:0] P5 = 64'd2870177450012600261;

  localparam int WORD_W  = 64;
  localparam int CNT_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CNT_W-1:0] FULL_CNT = 4'd8;

  // one classified request as it travels from front to back
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;   // 0..8, non-last words always 8
    logic              last;
  } xxh_item_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_init(input logic [63:0] s, input logic [1:0] idx);
    case (idx)
      2'd0:    lane_init = s + P1 + P2;
      2'd1:    lane_init = s + P2;
      2'd2:    lane_init = s;
      default: lane_init = s - P1;
    endcase
  endfunction

endpackage

>>> src/xxh64_front.sv
// ----------------------------------------------------------------------------
// xxh64_front: request intake
// Clamps the byte count, classifies the request and queues it for the back end.
// ----------------------------------------------------------------------------
module xxh64_front #(
  parameter int Depth = xxh64_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           in_word,
  input  logic [3:0]            in_cnt,
  input  logic                  in_last,
  output logic                  q_valid,
  input  logic                  q_pop,
  output xxh64_pkg::xxh_item_t  q_item
);
  import xxh64_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  xxh_item_t           entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  xxh_item_t           item_in;
  logic                push;
  logic                pop;

  // non-last words count as full; oversized counts clamp to 8
  always_comb begin
    item_in.word = in_word;
    item_in.last = in_last;
    if (!in_last || in_cnt > FULL_CNT) begin
      item_in.cnt = FULL_CNT;
    end else begin
      item_in.cnt = in_cnt;
    end
  end

  assign in_ready = (count != CntW'(Depth));
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule

>>> src/xxh64_mul.sv
// ----------------------------------------------------------------------------
// xxh64_mul: two-stage 64x64 multiplier, low 64 bits of the product
// Three 32x32 partial products, then two adds.
// ----------------------------------------------------------------------------
module xxh64_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] p_ll;
  logic [31:0] p_lh;
  logic [31:0] p_hl;
  logic        stage_v;

  always_ff @(posedge clk) begin
    p_ll <= a[31:0] * b[31:0];
    p_lh <= 32'(a[31:0] * b[63:32]);
    p_hl <= 32'(a[63:32] * b[31:0]);
    prod <= p_ll + {p_lh + p_hl, 32'd0};
    if (rst) begin
      stage_v <= 1'b0;
      done    <= 1'b0;
    end else begin
      stage_v <= go;
      done    <= stage_v;
    end
  end

endmodule

>>> src/xxh64_back.sv
// ----------------------------------------------------------------------------
// xxh64_back: hash sequencer
// Runs lane rounds, lane merge, tail folding and avalanche on one multiplier.
// ----------------------------------------------------------------------------
module xxh64_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [63:0]           cfg_seed,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  xxh64_pkg::xxh_item_t  q_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [63:0]           out_hash
);
  import xxh64_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LANE_A, ST_LANE_B, ST_LANE_C, ST_MERGE0, ST_TAIL, ST_HMUL,
    ST_AVAL, ST_PUT
  } state_t;

  typedef enum logic [1:0] {CTX_STRIPE, CTX_MERGE, CTX_FOLD} ctx_t;

  typedef enum logic [2:0] {
    HOP_MERGE, HOP_FOLD, HOP_CH4A, HOP_CH4B, HOP_BYTEA, HOP_BYTEB, HOP_AV1, HOP_AV2
  } hop_t;

  state_t       state;
  ctx_t         ctx;
  hop_t         hop;
  logic [63:0]  seed;
  logic [63:0]  lanes [4];
  logic [63:0]  pend [3];
  logic [1:0]   pcnt;
  logic         stripe;
  logic [63:0]  total;
  logic [63:0]  h;
  logic [1:0]   li;
  logic [2:0]   fi;
  logic [3:0]   pos;
  logic [3:0]   c;
  logic [63:0]  cur_w;
  logic         cur_last;
  logic         mul_go;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         mul_done;
  logic [63:0]  mul_p;
  logic [63:0]  wsel;
  logic [63:0]  lane_acc;
  logic [63:0]  lane_sum;
  logic [63:0]  hx;
  logic [63:0]  byte_v;

  xxh64_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_p)
  );

  function automatic logic [63:0] pend_at(input logic [63:0] p0, input logic [63:0] p1,
                                          input logic [63:0] p2, input logic [1:0] i);
    case (i)
      2'd0:    pend_at = p0;
      2'd1:    pend_at = p1;
      default: pend_at = p2;
    endcase
  endfunction

  always_comb begin
    case (ctx)
      CTX_STRIPE: wsel = (li == 2'd3) ? cur_w : pend_at(pend[0], pend[1], pend[2], li);
      CTX_MERGE:  wsel = lanes[li];
      default:    wsel = (fi < {1'b0, pcnt}) ? pend_at(pend[0], pend[1], pend[2], fi[1:0])
                                            : cur_w;
    endcase
    lane_acc = (ctx == CTX_STRIPE) ? lanes[li] : 64'd0;
    lane_sum = rotl64(lanes[0], 1) + rotl64(lanes[1], 7) + rotl64(lanes[2], 12)
             + rotl64(lanes[3], 18);
    hx       = h ^ mul_p;
    byte_v   = {56'd0, cur_w[{pos[2:0], 3'b000} +: 8]};
  end

  assign q_pop = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    mul_go <= 1'b0;
    if (rst) begin
      state     <= ST_IDLE;
      ctx       <= CTX_STRIPE;
      hop       <= HOP_MERGE;
      seed      <= '0;
      pcnt      <= '0;
      stripe    <= 1'b0;
      total     <= '0;
      li        <= '0;
      fi        <= '0;
      pos       <= '0;
      c         <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lanes[i] <= lane_init(64'd0, 2'(i));
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        seed   <= cfg_seed;
        pcnt   <= '0;
        stripe <= 1'b0;
        total  <= '0;
        for (int i = 0; i < 4; i++) begin
          lanes[i] <= lane_init(cfg_seed, 2'(i));
        end
      end else begin
        case (state)
          ST_IDLE: begin
            if (q_valid) begin
              cur_w    <= q_item.word;
              cur_last <= q_item.last;
              c        <= q_item.cnt;
              ctx      <= CTX_STRIPE;
              li       <= '0;
              if (!q_item.last && pcnt != 2'd3) begin
                case (pcnt)
                  2'd0:    pend[0] <= q_item.word;
                  2'd1:    pend[1] <= q_item.word;
                  default: pend[2] <= q_item.word;
                endcase
                pcnt  <= pcnt + 2'd1;
                total <= total + 64'd8;
              end else if (pcnt == 2'd3 && q_item.cnt == FULL_CNT) begin
                // word completes a stripe; on a last word the tail is then empty
                if (q_item.last) begin
                  c <= '0;
                end
                state <= ST_LANE_A;
              end else begin
                total <= total + {60'd0, q_item.cnt};
                state <= ST_MERGE0;
              end
            end
          end
          ST_LANE_A: begin
            mul_go <= 1'b1;
            mul_a  <= wsel;
            mul_b  <= P2;
            state  <= ST_LANE_B;
          end
          ST_LANE_B: begin
            if (mul_done) begin
              mul_go <= 1'b1;
              mul_a  <= rotl64(lane_acc + mul_p, 31);
              mul_b  <= P1;
              state  <= ST_LANE_C;
            end
          end
          ST_LANE_C: begin
            if (mul_done) begin
              case (ctx)
                CTX_STRIPE: begin
                  lanes[li] <= mul_p;
                  li        <= li + 2'd1;
                  if (li == 2'd3) begin
                    pcnt   <= '0;
                    stripe <= 1'b1;
                    total  <= total + 64'd8;
                    state  <= cur_last ? ST_MERGE0 : ST_IDLE;
                  end else begin
                    state <= ST_LANE_A;
                  end
                end
                CTX_MERGE: begin
                  mul_go <= 1'b1;
                  mul_a  <= hx;
                  mul_b  <= P1;
                  hop    <= HOP_MERGE;
                  state  <= ST_HMUL;
                end
                default: begin
                  mul_go <= 1'b1;
                  mul_a  <= rotl64(hx, 27);
                  mul_b  <= P1;
                  hop    <= HOP_FOLD;
                  state  <= ST_HMUL;
                end
              endcase
            end
          end
          ST_MERGE0: begin
            li  <= '0;
            fi  <= '0;
            pos <= '0;
            if (stripe) begin
              h     <= lane_sum;
              ctx   <= CTX_MERGE;
              state <= ST_LANE_A;
            end else begin
              h     <= seed + P5 + total;
              state <= ST_TAIL;
            end
          end
          ST_TAIL: begin
            ctx <= CTX_FOLD;
            if (fi < {1'b0, pcnt}) begin
              state <= ST_LANE_A;
            end else if (c == FULL_CNT && pos == '0) begin
              pos   <= FULL_CNT;
              state <= ST_LANE_A;
            end else if (c >= 4'd4 && pos == '0) begin
              pos    <= 4'd4;
              mul_go <= 1'b1;
              mul_a  <= {32'd0, cur_w[31:0]};
              mul_b  <= P1;
              hop    <= HOP_CH4A;
              state  <= ST_HMUL;
            end else if (pos < c) begin
              mul_go <= 1'b1;
              mul_a  <= byte_v;
              mul_b  <= P5;
              hop    <= HOP_BYTEA;
              state  <= ST_HMUL;
            end else begin
              state <= ST_AVAL;
            end
          end
          ST_HMUL: begin
            if (mul_done) begin
              case (hop)
                HOP_MERGE: begin
                  if (li == 2'd3) begin
                    h     <= mul_p + P4 + total;
                    state <= ST_TAIL;
                  end else begin
                    h     <= mul_p + P4;
                    li    <= li + 2'd1;
                    state <= ST_LANE_A;
                  end
                end
                HOP_FOLD: begin
                  h     <= mul_p + P4;
                  fi    <= fi + 3'd1;
                  state <= ST_TAIL;
                end
                HOP_CH4A: begin
                  h      <= hx;
                  mul_go <= 1'b1;
                  mul_a  <= rotl64(hx, 23);
                  mul_b  <= P2;
                  hop    <= HOP_CH4B;
                end
                HOP_CH4B: begin
                  h     <= mul_p + P3;
                  state <= ST_TAIL;
                end
                HOP_BYTEA: begin
                  mul_go <= 1'b1;
                  mul_a  <= rotl64(hx, 11);
                  mul_b  <= P1;
                  hop    <= HOP_BYTEB;
                end
                HOP_BYTEB: begin
                  h     <= mul_p;
                  pos   <= pos + 4'd1;
                  state <= ST_TAIL;
                end
                HOP_AV1: begin
                  mul_go <= 1'b1;
                  mul_a  <= mul_p ^ (mul_p >> 29);
                  mul_b  <= P3;
                  hop    <= HOP_AV2;
                end
                default: begin
                  h     <= mul_p ^ (mul_p >> 32);
                  state <= ST_PUT;
                end
              endcase
            end
          end
          ST_AVAL: begin
            mul_go <= 1'b1;
            mul_a  <= h ^ (h >> 33);
            mul_b  <= P2;
            hop    <= HOP_AV1;
            state  <= ST_HMUL;
          end
          ST_PUT: begin
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              out_hash  <= h;
              pcnt      <= '0;
              stripe    <= 1'b0;
              total     <= '0;
              for (int i = 0; i < 4; i++) begin
                lanes[i] <= lane_init(seed, 2'(i));
              end
              state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

>>> src/xxhash64_stream_hasher_unit.sv
// A word that only fills the stripe buffer is stored without leaving idle; the word
// that completes a stripe runs four lane rounds, each two products on the shared
// two-stage multiplier. A last word adds merge, tail folding and avalanche, one
// 64-bit product at a time.
// Throughput is bounded by the single multiplier; a 2-entry queue decouples intake.
// Reset (rst, synchronous) clears the seed to zero and restarts the message.
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_unit: streaming xxHash64
// Front queue, hash sequencer and output register.
// ----------------------------------------------------------------------------
module xxhash64_stream_hasher_unit #(
  parameter int QueueDepth = xxh64_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [63:0] data_word, [67:64] byte_count, [71:68] zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] hash_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);
  import xxh64_pkg::*;

  logic       q_valid;
  logic       q_pop;
  xxh_item_t  q_item;

  assign cfg_ready = 1'b1;

  xxh64_front #(.Depth(QueueDepth)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_word  (s_tdata[63:0]),
    .in_cnt   (s_tdata[67:64]),
    .in_last  (s_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  xxh64_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_seed  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_hash  (m_tdata)
  );

endmodule

>>> src/xxh64_checker.sv
// ----------------------------------------------------------------------------
// xxh64_checker: port-level checks for the hasher
// Reset, result hold, config acceptance and intake ready after reset.
// ----------------------------------------------------------------------------
module xxh64_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  a_rst_no_result: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("pending result dropped or changed");

  a_cfg_always: assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("config write stalled");

  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("intake not ready after reset");

endmodule

bind xxhash64_stream_hasher_unit xxh64_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
